// File: sv/art_pkg.sv
// Package for the ack and retransmit tracker: widths, mode and result codes.
// No dependencies; used by every module of the tracker.
`default_nettype none
package art_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int PEERS_DEF = 8;
  localparam int MODE_W = 3;
  localparam int PEER_W = 3;
  localparam int SEQ_W = 32;
  localparam int REF_W = 16;
  localparam int SLOTF_W = 4;
  localparam int TIME_W = 32;
  localparam int KIND_W = 3;
  localparam int TRY_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_ADD_UNI = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_BC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_RCP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ACK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLR_PEER = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLR_ALL = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CHECK = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD = 3'd7;

  localparam logic [KIND_W-1:0] KIND_RESEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DROP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD_SLOT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_ALLOC, OP_ADD_RCP, OP_SCAN, OP_FREE_SCAN,
    OP_CLR_ALL, OP_EMIT_RD, OP_EMIT, OP_REQUEUE, OP_STATUS, OP_CPEER
  } op_t;

  typedef struct packed {
    op_t op;
  } art_cmd_t;

  typedef struct packed {
    logic done;    // current walk finished
    logic found;   // walk located what it looked for
    logic due;     // front slot is due
    logic resend;  // front slot has tries left
    logic empty;   // no slot held
  } art_sts_t;
endpackage
`default_nettype wire

// File: sv/ack_retransmit_tracker_unit.sv
// The status is registered from the status state, after the walks that the item needs: an ack
// walks the order list, a clear-peer walks the slots, each freed slot adds a compaction walk,
// and a due check walks the peers of a due front slot, its emits coming out ahead of the status.
// Throughput: one item at a time; busy drops as the status is driven, so the next item
// can be accepted at the edge that ends that cycle. Results cannot be stalled.
// Synchronous active-low reset empties the table and restores register defaults.
// Depends on art_pkg, art_ctrl, art_dp.
`default_nettype none
module ack_retransmit_tracker_unit #(
  parameter int SLOTS = art_pkg::SLOTS_DEF,
  parameter int PEERS = art_pkg::PEERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [art_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [art_pkg::PEER_W-1:0]  in_peer,
  input  wire logic [art_pkg::SEQ_W-1:0]   in_sequence_no,
  input  wire logic [art_pkg::REF_W-1:0]   in_packet_ref,
  input  wire logic [art_pkg::SLOTF_W-1:0] in_slot,
  input  wire logic [art_pkg::TIME_W-1:0]  in_now,
  output logic                             out_valid,
  output logic [art_pkg::KIND_W-1:0]       out_kind,
  output logic [art_pkg::PEER_W-1:0]       out_peer_res,
  output logic [art_pkg::SEQ_W-1:0]        out_sequence_no_res,
  output logic [art_pkg::REF_W-1:0]        out_packet_ref_res,
  output logic [art_pkg::SLOTF_W-1:0]      out_slot_out,
  output logic [art_pkg::TIME_W-1:0]       out_wait_time,
  output logic                             out_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [art_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                 cfg_data
);
  import art_pkg::*;

  art_cmd_t cmd;
  art_sts_t sts;

  assign cfg_ready = 1'b1;

  art_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode), .busy(busy),
    .cmd(cmd), .sts(sts)
  );

  art_dp #(.SLOTS(SLOTS), .PEERS(PEERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .in_mode(in_mode), .in_peer(in_peer), .in_sequence_no(in_sequence_no),
    .in_packet_ref(in_packet_ref), .in_slot(in_slot), .in_now(in_now),
    .out_valid(out_valid), .out_kind(out_kind), .out_peer_res(out_peer_res),
    .out_sequence_no_res(out_sequence_no_res), .out_packet_ref_res(out_packet_ref_res),
    .out_slot_out(out_slot_out), .out_wait_time(out_wait_time), .out_last(out_last)
  );
endmodule
`default_nettype wire

// File: sv/art_ctrl.sv
// Controller for the tracker: sequences the walks of one transaction.
// Depends on art_pkg.
`default_nettype none
module art_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [art_pkg::MODE_W-1:0] in_mode,
  output logic                          busy,
  output art_pkg::art_cmd_t             cmd,
  input  art_pkg::art_sts_t             sts
);
  import art_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_SCAN = 4'd2, S_FREE = 4'd3,
                         S_EMRD = 4'd4, S_EMIT = 4'd5, S_REQ = 4'd6, S_STAT = 4'd7,
                         S_CPEER = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    if (start && !busy) mode_r <= in_mode;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.op = OP_LATCH;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (mode_r) inside
          MODE_ADD_UNI, MODE_ADD_BC: begin cmd.op = OP_ALLOC; state_nxt = S_STAT; end
          MODE_ADD_RCP: begin cmd.op = OP_ADD_RCP; state_nxt = S_STAT; end
          MODE_ACK: state_nxt = S_SCAN;
          MODE_CLR_PEER: state_nxt = S_CPEER;
          MODE_CLR_ALL: begin cmd.op = OP_CLR_ALL; state_nxt = S_STAT; end
          MODE_CHECK: state_nxt = (!sts.empty && sts.due) ? S_EMRD : S_STAT;
          default: state_nxt = S_STAT;
        endcase
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.found) state_nxt = S_FREE;
        else if (sts.done) state_nxt = S_STAT;
      end
      S_CPEER: begin
        cmd.op = OP_CPEER;
        if (sts.found) state_nxt = S_FREE;
        else if (sts.done) state_nxt = S_STAT;
      end
      S_FREE: begin
        cmd.op = OP_FREE_SCAN;
        if (sts.done) state_nxt = (mode_r == MODE_CLR_PEER) ? S_CPEER : S_STAT;
      end
      S_EMRD: begin cmd.op = OP_EMIT_RD; state_nxt = S_EMIT; end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        state_nxt = sts.done ? S_REQ : S_EMRD;
      end
      S_REQ: begin
        cmd.op = OP_REQUEUE;
        if (sts.resend) state_nxt = S_STAT;
        else state_nxt = S_FREE;
      end
      S_STAT: begin cmd.op = OP_STATUS; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_DISP)
    else $error("item not dispatched");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STAT |=> state_r == S_IDLE)
    else $error("status not final");
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (cmd.op == OP_NONE || cmd.op == OP_LATCH))
    else $error("command while idle");
endmodule
`default_nettype wire

// File: sv/art_dp.sv
// Datapath for the tracker: slot tables, order list, sequence memory, result regs.
// Depends on art_pkg.
`default_nettype none
module art_dp #(
  parameter int SLOTS = art_pkg::SLOTS_DEF,
  parameter int PEERS = art_pkg::PEERS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  art_pkg::art_cmd_t               cmd,
  output art_pkg::art_sts_t               sts,
  input  wire logic                       cfg_we,
  input  wire logic [art_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [31:0]                cfg_wdata,
  input  wire logic [art_pkg::MODE_W-1:0] in_mode,
  input  wire logic [art_pkg::PEER_W-1:0] in_peer,
  input  wire logic [art_pkg::SEQ_W-1:0]  in_sequence_no,
  input  wire logic [art_pkg::REF_W-1:0]  in_packet_ref,
  input  wire logic [art_pkg::SLOTF_W-1:0] in_slot,
  input  wire logic [art_pkg::TIME_W-1:0] in_now,
  output logic                            out_valid,
  output logic [art_pkg::KIND_W-1:0]      out_kind,
  output logic [art_pkg::PEER_W-1:0]      out_peer_res,
  output logic [art_pkg::SEQ_W-1:0]       out_sequence_no_res,
  output logic [art_pkg::REF_W-1:0]       out_packet_ref_res,
  output logic [art_pkg::SLOTF_W-1:0]     out_slot_out,
  output logic [art_pkg::TIME_W-1:0]      out_wait_time,
  output logic                            out_last
);
  import art_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int PCW = $clog2(PEERS + 1);
  localparam int AW = SW + PW;

  logic [31:0] ack_timeout_r;
  logic [TRY_W-1:0] retry_limit_r;

  logic [SLOTS-1:0] valid_r;
  logic [PEERS-1:0] rcp_r [SLOTS];
  logic [REF_W-1:0] dref_r [SLOTS];
  logic [TIME_W-1:0] stime_r [SLOTS];
  logic [TRY_W-1:0] tries_r [SLOTS];
  logic [SW-1:0] olist_r [SLOTS];
  logic [CW-1:0] ocnt_r;
  logic [SEQ_W-1:0] seq_mem [SLOTS*PEERS];
  logic [SEQ_W-1:0] seq_rd_r;

  logic [MODE_W-1:0] mode_r;
  logic [PEER_W-1:0] peer_r;
  logic [SEQ_W-1:0] seqin_r;
  logic [REF_W-1:0] ref_r;
  logic [SLOTF_W-1:0] slin_r;
  logic [TIME_W-1:0] now_r;
  logic [KIND_W-1:0] kind_r;
  logic [SLOTF_W-1:0] slres_r;

  logic [CW-1:0] idx_r;        // walk index over order list or slots
  logic [CW-1:0] wr_r;         // compaction write index
  logic [SW-1:0] tgt_r;        // slot being worked on
  logic [PCW-1:0] pidx_r;      // emit walk peer index
  logic rd_pend_r;             // scan waits for a sequence read
  logic [SW-1:0] front;
  logic peer_ok;
  logic [SLOTS-1:0] free_vec;
  logic [SW-1:0] free_idx;
  logic free_any;
  logic [TIME_W-1:0] el, fwait;
  logic [SW-1:0] cur_slot;
  logic cur_hit;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic [PW-1:0] pp;
  logic [SW-1:0] slin_idx;
  logic slin_ok;
  logic sq_we;
  logic [AW-1:0] sq_waddr;

  assign front = olist_r[0];
  assign peer_ok = (PEERS >= 8) || ({1'b0, peer_r} < (PEER_W + 1)'(PEERS));
  assign pp = PW'(peer_r);
  assign el = now_r - stime_r[front];
  assign fwait = (ocnt_r == '0) ? '1 : ((el < ack_timeout_r) ? ack_timeout_r - el : '0);
  assign slin_idx = SW'(slin_r);
  assign slin_ok = ((SLOTS >= (1 << SLOTF_W)) || ({1'b0, slin_r} < (SLOTF_W + 1)'(SLOTS))) &&
                   valid_r[slin_idx];

  always_comb begin
    free_vec = ~valid_r;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (free_vec[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
  end

  // Slot under test in the ack walk (order list) or the clear-peer walk (slot index).
  assign cur_slot = (mode_r == MODE_ACK) ? olist_r[idx_r[SW-1:0]] : idx_r[SW-1:0];
  assign cur_hit = rcp_r[cur_slot][pp] && (mode_r != MODE_ACK || seq_rd_r == seqin_r);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = {cur_slot, pp};
    if (cmd.op == OP_SCAN && !rd_pend_r) rd_en = 1'b1;
    if (cmd.op == OP_EMIT_RD) begin
      rd_en = 1'b1;
      rd_addr = {front, pidx_r[PW-1:0]};
    end
  end

  always_comb begin
    sq_we = 1'b0;
    sq_waddr = {slin_idx, pp};
    if (cmd.op == OP_ADD_RCP && slin_ok && peer_ok) sq_we = 1'b1;
    if (cmd.op == OP_ALLOC && mode_r == MODE_ADD_UNI && peer_ok && free_any &&
        ocnt_r < CW'(SLOTS)) begin
      sq_we = 1'b1;
      sq_waddr = {free_idx, pp};
    end
  end

  always_comb begin
    sts.empty = (ocnt_r == '0);
    sts.due = (fwait == '0);
    sts.resend = (tries_r[front] != '0);
    sts.found = 1'b0;
    sts.done = 1'b0;
    case (cmd.op)
      OP_SCAN: begin
        sts.done = (idx_r >= ocnt_r) || !peer_ok;
        sts.found = !sts.done && rd_pend_r && cur_hit &&
                    (rcp_r[cur_slot] & ~(PEERS'(1) << pp)) == '0;
      end
      OP_CPEER: begin
        sts.done = (idx_r >= CW'(SLOTS)) || !peer_ok;
        sts.found = !sts.done && valid_r[cur_slot] && cur_hit &&
                    (rcp_r[cur_slot] & ~(PEERS'(1) << pp)) == '0;
      end
      OP_FREE_SCAN: sts.done = (idx_r >= ocnt_r);
      OP_EMIT: sts.done = (pidx_r >= PCW'(PEERS - 1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) seq_rd_r <= seq_mem[rd_addr];
    if (sq_we) seq_mem[sq_waddr] <= seqin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= 32'd1000;
      retry_limit_r <= TRY_W'(3);
      valid_r <= '0;
      for (int i = 0; i < SLOTS; i++) rcp_r[i] <= '0;
      ocnt_r <= '0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      out_valid <= (cmd.op == OP_STATUS) ||
                   (cmd.op == OP_EMIT && rcp_r[front][pidx_r[PW-1:0]]);
      if (cfg_we) begin
        if (cfg_idx == CFG_ACK_TIMEOUT) ack_timeout_r <= cfg_wdata;
        else retry_limit_r <= cfg_wdata[TRY_W-1:0];
      end
      case (cmd.op)
        OP_LATCH: begin
          mode_r <= in_mode; peer_r <= in_peer; seqin_r <= in_sequence_no;
          ref_r <= in_packet_ref; slin_r <= in_slot; now_r <= in_now;
          kind_r <= KIND_OK; slres_r <= '0; idx_r <= '0; wr_r <= '0;
          pidx_r <= '0; rd_pend_r <= 1'b0;
        end
        OP_ALLOC: begin
          if (mode_r == MODE_ADD_UNI && !peer_ok) ;
          else if (!free_any || ocnt_r >= CW'(SLOTS)) kind_r <= KIND_FULL;
          else begin
            valid_r[free_idx] <= 1'b1;
            dref_r[free_idx] <= ref_r;
            stime_r[free_idx] <= now_r;
            tries_r[free_idx] <= retry_limit_r;
            rcp_r[free_idx] <= (mode_r == MODE_ADD_UNI) ? (PEERS'(1) << pp) : '0;
            olist_r[ocnt_r[SW-1:0]] <= free_idx;
            ocnt_r <= ocnt_r + 1'b1;
            if (mode_r == MODE_ADD_BC) slres_r <= SLOTF_W'(free_idx);
          end
        end
        OP_ADD_RCP: begin
          if (!slin_ok) kind_r <= KIND_BAD_SLOT;
          else if (peer_ok) rcp_r[slin_idx][pp] <= 1'b1;
        end
        OP_SCAN: begin
          if (!sts.done) begin
            if (!rd_pend_r) rd_pend_r <= 1'b1;
            else begin
              rd_pend_r <= 1'b0;
              if (cur_hit) begin
                rcp_r[cur_slot][pp] <= 1'b0;
                tgt_r <= cur_slot;
                // A freed slot restarts the index for compaction; otherwise the walk stops.
                if (sts.found) begin
                  idx_r <= '0; wr_r <= '0;
                end else idx_r <= CW'(SLOTS);
              end else idx_r <= idx_r + 1'b1;
            end
          end
        end
        OP_CPEER: begin
          if (!sts.done) begin
            if (valid_r[cur_slot] && rcp_r[cur_slot][pp]) rcp_r[cur_slot][pp] <= 1'b0;
            if (sts.found) begin
              tgt_r <= cur_slot;
              wr_r <= '0;
              idx_r <= '0;
            end else idx_r <= idx_r + 1'b1;
          end
        end
        OP_FREE_SCAN: begin
          if (!sts.done) begin
            if (olist_r[idx_r[SW-1:0]] != tgt_r) begin
              olist_r[wr_r[SW-1:0]] <= olist_r[idx_r[SW-1:0]];
              wr_r <= wr_r + 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end else begin
            ocnt_r <= wr_r;
            valid_r[tgt_r] <= 1'b0;
            rcp_r[tgt_r] <= '0;
            // Clear-peer resumes after the freed slot; other walks end.
            idx_r <= (mode_r == MODE_CLR_PEER) ? (CW'(tgt_r) + 1'b1) : CW'(SLOTS);
          end
        end
        OP_CLR_ALL: begin
          valid_r <= '0;
          for (int i = 0; i < SLOTS; i++) rcp_r[i] <= '0;
          ocnt_r <= '0;
        end
        OP_EMIT: begin
          if (rcp_r[front][pidx_r[PW-1:0]]) begin
            out_kind <= (tries_r[front] != '0) ? KIND_RESEND : KIND_DROP;
            out_peer_res <= PEER_W'(pidx_r);
            out_sequence_no_res <= seq_rd_r;
            out_packet_ref_res <= (tries_r[front] != '0) ? dref_r[front] : '0;
            out_slot_out <= '0; out_wait_time <= '0; out_last <= 1'b0;
          end
          pidx_r <= pidx_r + 1'b1;
        end
        OP_REQUEUE: begin
          tgt_r <= front;
          idx_r <= '0; wr_r <= '0;
          if (tries_r[front] != '0) begin
            tries_r[front] <= tries_r[front] - 1'b1;
            stime_r[front] <= now_r;
            for (int i = 0; i < SLOTS - 1; i++)
              if (CW'(i + 1) < ocnt_r) olist_r[i] <= olist_r[i + 1];
            olist_r[SW'(ocnt_r - 1'b1)] <= front;
          end
        end
        OP_STATUS: begin
          out_kind <= kind_r; out_peer_res <= '0; out_sequence_no_res <= '0;
          out_packet_ref_res <= '0; out_slot_out <= slres_r;
          out_wait_time <= fwait; out_last <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) ocnt_r <= CW'(SLOTS))
    else $error("order count overflow");
  a_vc: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(ocnt_r) || cmd.op != OP_STATUS)
    else $error("valid count mismatch");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind != KIND_RESEND && out_kind != KIND_DROP))
    else $error("status kind wrong");
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the ack and retransmit tracker unit.
// Depends on art_pkg and ack_retransmit_tracker_unit; predicts every result.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import art_pkg::*;

  localparam int NSLOT = 16;
  localparam int NPEER = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [PEER_W-1:0] in_peer = '0;
  logic [SEQ_W-1:0] in_sequence_no = '0;
  logic [REF_W-1:0] in_packet_ref = '0;
  logic [SLOTF_W-1:0] in_slot = '0;
  logic [TIME_W-1:0] in_now = '0;
  logic out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [PEER_W-1:0] out_peer_res;
  logic [SEQ_W-1:0] out_sequence_no_res;
  logic [REF_W-1:0] out_packet_ref_res;
  logic [SLOTF_W-1:0] out_slot_out;
  logic [TIME_W-1:0] out_wait_time;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ack_retransmit_tracker_unit u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PEER_W-1:0] peer;
    logic [SEQ_W-1:0] seq;
    logic [REF_W-1:0] pref;
    logic [SLOTF_W-1:0] slot;
    logic [TIME_W-1:0] wait_t;
    logic last;
  } event_t;

  event_t pending_events[$];
  int errors = 0;
  int cycles = 0;
  logic [15:0] now_base = '0;
  logic [31:0] tnow = 32'd0;

  // Shadow of the tracker's table.
  logic [31:0] timeout_reg;
  logic [3:0] retries_reg;
  logic slot_used[NSLOT];
  logic [15:0] slot_ref[NSLOT];
  logic [31:0] slot_sent[NSLOT];
  logic [3:0] slot_left[NSLOT];
  logic [7:0] slot_peers[NSLOT];
  logic [31:0] peer_seq[NSLOT][NPEER];
  int queue_order[$];

  function automatic logic [31:0] front_delay(logic [31:0] now);
    logic [31:0] el;
    if (queue_order.size() == 0) return 32'hFFFF_FFFF;
    el = now - slot_sent[queue_order[0]];
    return (el < timeout_reg) ? timeout_reg - el : 32'd0;
  endfunction

  function automatic void release_slot(int s);
    int idx[$];
    idx = queue_order.find_first_index(x) with (x == s);
    if (idx.size() != 0) queue_order.delete(idx[0]);
    slot_used[s] = 1'b0;
    slot_peers[s] = '0;
  endfunction

  function automatic int grab_slot(logic [15:0] pref, logic [31:0] now);
    if (queue_order.size() >= NSLOT) return -1;
    for (int s = 0; s < NSLOT; s++) begin
      if (!slot_used[s]) begin
        slot_used[s] = 1'b1;
        slot_ref[s] = pref;
        slot_sent[s] = now;
        slot_left[s] = retries_reg;
        slot_peers[s] = '0;
        queue_order.insert(queue_order.size(), s);
        return s;
      end
    end
    return -1;
  endfunction

  function automatic void predict_tracker(logic [2:0] mode, logic [2:0] peer,
      logic [31:0] seq, logic [15:0] pref, logic [3:0] sl, logic [31:0] now);
    event_t ev;
    logic [KIND_W-1:0] kind;
    logic [3:0] given;
    int s, t;
    logic resend;
    kind = KIND_OK;
    given = '0;
    case (mode)
      MODE_ADD_UNI: begin
        s = grab_slot(pref, now);
        if (s < 0) kind = KIND_FULL;
        else begin
          slot_peers[s] = 8'd1 << peer;
          peer_seq[s][peer] = seq;
        end
      end
      MODE_ADD_BC: begin
        s = grab_slot(pref, now);
        if (s < 0) kind = KIND_FULL;
        else given = s[3:0];
      end
      MODE_ADD_RCP: begin
        if (!slot_used[sl]) kind = KIND_BAD_SLOT;
        else begin
          slot_peers[sl][peer] = 1'b1;
          peer_seq[sl][peer] = seq;
        end
      end
      MODE_ACK: begin
        foreach (queue_order[i]) begin
          t = queue_order[i];
          if (slot_peers[t][peer] && peer_seq[t][peer] == seq) begin
            slot_peers[t][peer] = 1'b0;
            if (slot_peers[t] == 0) release_slot(t);
            break;
          end
        end
      end
      MODE_CLR_PEER: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_used[i] && slot_peers[i][peer]) begin
            slot_peers[i][peer] = 1'b0;
            if (slot_peers[i] == 0) release_slot(i);
          end
        end
      end
      MODE_CLR_ALL: begin
        for (int i = 0; i < NSLOT; i++) begin
          slot_used[i] = 1'b0;
          slot_peers[i] = '0;
        end
        queue_order.delete();
      end
      MODE_CHECK: begin
        if (queue_order.size() != 0 && front_delay(now) == 0) begin
          t = queue_order[0];
          resend = slot_left[t] != 0;
          for (int i = 0; i < NPEER; i++) begin
            if (slot_peers[t][i]) begin
              ev = '0;
              ev.kind = resend ? KIND_RESEND : KIND_DROP;
              ev.peer = i[2:0];
              ev.seq = peer_seq[t][i];
              ev.pref = resend ? slot_ref[t] : '0;
              pending_events.insert(pending_events.size(), ev);
            end
          end
          if (resend) begin
            slot_left[t] = slot_left[t] - 4'd1;
            slot_sent[t] = now;
            queue_order.delete(0);
            queue_order.insert(queue_order.size(), t);
          end else begin
            release_slot(t);
          end
        end
      end
      default: ;
    endcase
    ev = '0;
    ev.kind = kind;
    ev.slot = given;
    ev.wait_t = front_delay(now);
    ev.last = 1'b1;
    pending_events.insert(pending_events.size(), ev);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      event_t e;
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_kind), 32'd0);
      end else begin
        e = pending_events[0];
        pending_events.delete(0);
        if (out_kind !== e.kind) report_mismatch("kind", 32'(out_kind), 32'(e.kind));
        if (out_peer_res !== e.peer)
          report_mismatch("peer", 32'(out_peer_res), 32'(e.peer));
        if (out_sequence_no_res !== e.seq)
          report_mismatch("sequence", out_sequence_no_res, e.seq);
        if (out_packet_ref_res !== e.pref)
          report_mismatch("packet ref", 32'(out_packet_ref_res), 32'(e.pref));
        if (out_slot_out !== e.slot)
          report_mismatch("slot", 32'(out_slot_out), 32'(e.slot));
        if (out_wait_time !== e.wait_t) report_mismatch("wait", out_wait_time, e.wait_t);
        if (out_last !== e.last) report_mismatch("last", 32'(out_last), 32'(e.last));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] mode, logic [2:0] peer, logic [31:0] seq,
      logic [15:0] pref, logic [3:0] sl, logic [31:0] now);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_peer <= peer;
    in_sequence_no <= seq;
    in_packet_ref <= pref;
    in_slot <= sl;
    in_now <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_tracker(mode, peer, seq, pref, sl, now);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ACK_TIMEOUT) timeout_reg = value;
    else retries_reg = value[3:0];
  endtask

  // Time advances a random step so checks land both before and after due.
  function automatic logic [31:0] next_time();
    tnow = tnow + $urandom_range(0, 2 * timeout_reg > 600 ? 600 : 2 * timeout_reg);
    return tnow;
  endfunction

  function automatic logic [3:0] used_slot();
    if (queue_order.size() == 0) return 4'd0;
    return 4'(queue_order[$urandom_range(0, queue_order.size() - 1)]);
  endfunction

  task automatic test_directed();
    send_item(MODE_CHECK, 3'd0, 32'd0, 16'd0, 4'd0, 32'd0);
    send_item(MODE_ADD_RCP, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 4'd15, 32'd5);
    send_item(MODE_ADD_UNI, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 32'hFFFF_FFF0);
    send_item(MODE_ADD_BC, 3'd0, 32'd0, 16'h0000, 4'd0, 32'hFFFF_FFF8);
    send_item(MODE_ADD_RCP, 3'd0, 32'd0, 16'd0, 4'd1, 32'hFFFF_FFF8);
    send_item(MODE_ADD_RCP, 3'd0, 32'd9, 16'd0, 4'd1, 32'hFFFF_FFF8);
    send_item(MODE_ADD_RCP, 3'd5, 32'h8000_0000, 16'd0, 4'd1, 32'hFFFF_FFF8);
    send_item(MODE_CHECK, 3'd0, 32'd0, 16'd0, 4'd0, 32'h0000_0010);
    send_item(MODE_CHECK, 3'd0, 32'd0, 16'd0, 4'd0, 32'h0000_0400);
    send_item(MODE_ACK, 3'd0, 32'd0, 16'd0, 4'd0, 32'h0000_0400);
    send_item(MODE_ACK, 3'd0, 32'd9, 16'd0, 4'd0, 32'h0000_0400);
    send_item(MODE_RSVD, 3'd3, 32'd1, 16'd1, 4'd1, 32'h0000_0400);
    send_item(MODE_ADD_BC, 3'd0, 32'd0, 16'h1234, 4'd0, 32'h0000_0400);
    send_item(MODE_CLR_PEER, 3'd5, 32'd0, 16'd0, 4'd0, 32'h0000_0500);
    for (int i = 0; i < 17; i++)
      send_item(MODE_ADD_UNI, i[2:0], i, i[15:0], 4'd0, 32'h600);
    send_item(MODE_CLR_ALL, 3'd0, 32'd0, 16'd0, 4'd0, 32'h700);
  endtask

  // Retry exhaustion: a single short timeout with no retries drops at once.
  task automatic test_retry_exhaustion();
    write_register(CFG_RETRY_LIMIT, 32'd0);
    write_register(CFG_ACK_TIMEOUT, 32'd1);
    send_item(MODE_ADD_UNI, 3'd2, 32'd77, 16'hBEEF, 4'd0, 32'd100);
    send_item(MODE_CHECK, 3'd0, 32'd0, 16'd0, 4'd0, 32'd100);
    send_item(MODE_CHECK, 3'd0, 32'd0, 16'd0, 4'd0, 32'd101);
  endtask

  task automatic test_random(int count, logic [31:0] timeout, logic [3:0] retries);
    int pick;
    logic [2:0] mode;
    write_register(CFG_ACK_TIMEOUT, timeout);
    write_register(CFG_RETRY_LIMIT, {28'd0, retries});
    send_item(MODE_CLR_ALL, 3'd0, 32'd0, 16'd0, 4'd0, tnow);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) mode = MODE_ADD_UNI;
      else if (pick < 32) mode = MODE_ADD_BC;
      else if (pick < 50) mode = MODE_ADD_RCP;
      else if (pick < 64) mode = MODE_ACK;
      else if (pick < 69) mode = MODE_CLR_PEER;
      else if (pick < 71) mode = MODE_CLR_ALL;
      else if (pick < 98) mode = MODE_CHECK;
      else mode = MODE_RSVD;
      // Acks mostly reuse the stored sequence number of a random peer on a used slot.
      if (mode == MODE_ACK && queue_order.size() != 0 && $urandom_range(0, 3) != 0) begin
        logic [3:0] s;
        logic [2:0] p;
        s = used_slot();
        p = 3'($urandom_range(0, 7));
        send_item(mode, p, peer_seq[s][p], 16'd0, 4'd0, next_time());
      end else begin
        send_item(mode, 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 7),
                  16'($urandom_range(0, 65535)),
                  ($urandom_range(0, 4) != 0) ? used_slot() : 4'($urandom_range(0, 15)),
                  next_time());
      end
    end
  endtask

  initial begin
    timeout_reg = 32'd1000;
    retries_reg = 4'd3;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0;
      slot_peers[i] = '0;
      for (int j = 0; j < NPEER; j++) peer_seq[i][j] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_retry_exhaustion();
    test_random(38, 32'd200, 4'd2);
    test_random(38, 32'hFFFF_FFFF, 4'd15);
    test_random(38, 32'd40, 4'd1);
    drain_results();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
